[design/fwlt_pkg.sv]
// ----------------------------------------------------------------------------
// fwlt_pkg: shared types, codes and helpers for the wear-level translator
// widths, command and result codes, register indexes and clamping helpers
// ----------------------------------------------------------------------------
package fwlt_pkg;

    localparam int ADDR_W  = 32;
    localparam int POS_W   = 16;
    localparam int SHIFT_W = 5;
    localparam int STRIDE_W = 9;
    localparam int MARK_W  = POS_W + STRIDE_W;
    localparam int CMD_W   = 2;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 96;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [OP_W-1:0]    op_t;
    typedef logic [CMD_W-1:0]   cmd_t;

    // input commands
    localparam cmd_t CMD_TRANSLATE = 2'd0;
    localparam cmd_t CMD_ERASE     = 2'd1;
    localparam cmd_t CMD_RESTORE   = 2'd2;

    // result operations
    localparam op_t OP_ACCESS     = 3'd0;
    localparam op_t OP_ERASE_PAGE = 3'd1;
    localparam op_t OP_COPY_PAGE  = 3'd2;
    localparam op_t OP_MARK_USED  = 3'd3;
    localparam op_t OP_SAVE_STATE = 3'd4;
    localparam op_t OP_ERASE_BLK  = 3'd5;
    localparam op_t OP_RANGE_ERR  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USABLE_PAGES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_SHIFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_STRIDE  = 3'd4;

    function automatic shift_t clamp_shift(input shift_t v, input shift_t lo,
                                           input shift_t hi);
        if (v < lo)
            return lo;
        else if (v > hi)
            return hi;
        else
            return v;
    endfunction

    function automatic pos_t eff_pages(input pos_t v);
        return (v < pos_t'(2)) ? pos_t'(2) : v;
    endfunction

    // virtual offset (below the usable size) to physical byte address
    function automatic addr_t translate(input addr_t voff, input pos_t rot,
                                        input pos_t pos, input shift_t ps,
                                        input addr_t usable, input addr_t base);
        addr_t rot_bytes;
        addr_t pos_bytes;
        addr_t page_bytes;
        addr_t r;
        rot_bytes  = addr_t'(rot) << ps;
        pos_bytes  = addr_t'(pos) << ps;
        page_bytes = addr_t'(1) << ps;
        if (voff >= rot_bytes)
            r = voff - rot_bytes;
        else
            r = voff + usable - rot_bytes;
        if (r >= pos_bytes)
            r = r + page_bytes;
        return base + r;
    endfunction

endpackage

[design/flash_wear_level_translator_core.sv]
// ----------------------------------------------------------------------------
// flash_wear_level_translator_core: rotating dummy-page address translator
// maps virtual flash addresses to physical ones and expands sector erases
// into the dummy-page rotation sequence
// ----------------------------------------------------------------------------
// An accepted item is registered in the input register and its first
// result is presented on the master side from the result run register.
// Translations run at one item per cycle while the sink takes results and
// no remainder pass runs; an in-range sector erase gives a run of four or
// five results, one per cycle while the sink takes them, and the next item
// enters as the last one of the run leaves. The rotation uses the wrap
// count modulo the usable page count, kept in a register; a restore, or a
// write of usable_pages, recomputes it in a bit-serial remainder unit,
// during which at most one more item is taken in and held in the input
// register (configuration writes are taken as ever).
module flash_wear_level_translator_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fwlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fwlt_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fwlt_pkg::IN_DATA_W-1:0]  s_tdata,  // vaddr, sector, restore_pos, restore_moves
    input  logic [fwlt_pkg::CMD_W-1:0]      s_tuser,  // cmd
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fwlt_pkg::OUT_DATA_W-1:0] m_tdata,  // addr, copy_src, pos_out, moves_out
    output logic [fwlt_pkg::OP_W-1:0]       m_tuser,  // op
    output logic                            m_tlast   // last
);
    import fwlt_pkg::*;

    localparam int CNT_W = $clog2(POS_W + 1);

    // configuration registers
    addr_t                base_addr_reg;
    pos_t                 usable_pages_reg;
    shift_t               page_shift_reg;
    shift_t               sector_shift_reg;
    logic [STRIDE_W-1:0]  mark_stride_reg;

    // rotation state
    pos_t dummy_pos_reg;
    pos_t wrap_count_reg;
    pos_t wrap_mod_reg;

    // remainder unit
    logic             mod_busy_reg;
    logic [CNT_W-1:0] mod_cnt_reg;
    pos_t             mod_rem_reg;
    pos_t             mod_w_reg;

    // input register
    logic  s1_valid_reg;
    cmd_t  s1_cmd_reg;
    addr_t s1_vaddr_reg;
    pos_t  s1_sector_reg;
    pos_t  s1_rpos_reg;
    pos_t  s1_rmoves_reg;

    // result run register
    logic              run_valid_reg;
    logic              run_erase_reg;
    op_t               run_op_reg;
    logic [2:0]        run_idx_reg;
    addr_t             run_addr_reg;
    addr_t             run_dst_reg;
    addr_t             run_src_reg;
    logic [MARK_W-1:0] run_mark_reg;
    logic              run_save_reg;
    pos_t              run_pos_reg;
    pos_t              run_moves_reg;

    // derived configuration
    pos_t                pages;
    shift_t              ps;
    shift_t              ss;
    logic [STRIDE_W-1:0] stride;
    addr_t               usable_bytes;
    logic [POS_W:0]      slots;

    assign pages        = eff_pages(usable_pages_reg);
    assign ps           = clamp_shift(page_shift_reg, 5'd8, 5'd16);
    assign ss           = clamp_shift(sector_shift_reg, 5'd8, 5'd18);
    assign stride       = (mark_stride_reg == '0) ? STRIDE_W'(1) :
                          (mark_stride_reg > STRIDE_W'(256)) ? STRIDE_W'(256) :
                          mark_stride_reg;
    assign usable_bytes = addr_t'(pages) << ps;
    assign slots        = {1'b0, pages} + (POS_W+1)'(1);

    // ---------------- step logic ----------------
    logic [ADDR_W+POS_W+2:0] sec_wide;
    addr_t             va_erase;
    logic              in_range;
    logic [POS_W:0]    np_wide;
    logic              wraps;
    pos_t              nxt;
    pos_t              moves_inc;
    pos_t              moves_wrap;
    pos_t              pos_next;
    pos_t              moves_next;
    pos_t              rot_next;
    addr_t             dst;
    addr_t             src;
    logic [MARK_W-1:0] mark;
    addr_t             tr_voff;
    pos_t              tr_rot;
    pos_t              tr_pos;
    addr_t             tr_addr;
    pos_t              restore_p;
    logic              s1_has_result;
    logic              run_last;
    logic              run_free;
    logic              s1_adv;
    logic              is_erase;

    assign sec_wide  = (ADDR_W+POS_W+3)'(s1_sector_reg) << ss;
    assign va_erase  = sec_wide[ADDR_W-1:0];
    assign is_erase  = (s1_cmd_reg == CMD_ERASE);
    assign in_range  = is_erase ? (va_erase < usable_bytes)
                                : (s1_vaddr_reg < usable_bytes);

    assign np_wide    = {1'b0, dummy_pos_reg} + (POS_W+1)'(1);
    assign wraps      = (np_wide >= slots);
    assign nxt        = wraps ? '0 : np_wide[POS_W-1:0];
    assign moves_inc  = wrap_count_reg + pos_t'(1);
    assign moves_wrap = (moves_inc >= pages) ? '0 : moves_inc;
    assign pos_next   = nxt;
    assign moves_next = wraps ? moves_wrap : wrap_count_reg;
    assign rot_next   = wraps ? moves_wrap : wrap_mod_reg;

    assign dst  = base_addr_reg + (addr_t'(dummy_pos_reg) << ps);
    assign src  = base_addr_reg + (addr_t'(nxt) << ps);
    assign mark = {{STRIDE_W{1'b0}}, dummy_pos_reg} * {{POS_W{1'b0}}, stride};

    // erase translates with the state after the rotation step
    assign tr_voff = is_erase ? va_erase : s1_vaddr_reg;
    assign tr_rot  = is_erase ? rot_next : wrap_mod_reg;
    assign tr_pos  = is_erase ? pos_next : dummy_pos_reg;
    assign tr_addr = translate(tr_voff, tr_rot, tr_pos, ps, usable_bytes, base_addr_reg);

    assign restore_p = (s1_rpos_reg > pages) ? pages : s1_rpos_reg;

    assign s1_has_result = (s1_cmd_reg == CMD_TRANSLATE) || is_erase;
    assign run_free      = !run_valid_reg || (m_tready && run_last);
    assign s1_adv        = s1_valid_reg && !mod_busy_reg && (!s1_has_result || run_free);
    assign s_tready      = !s1_valid_reg || s1_adv;
    assign cfg_ready     = 1'b1;

    // ---------------- result beat selection ----------------
    op_t   beat_op;
    addr_t beat_addr;
    addr_t beat_src;

    always_comb
    begin
        beat_src = '0;
        if (!run_erase_reg)
        begin
            beat_op   = run_op_reg;
            beat_addr = run_addr_reg;
        end
        else
        begin
            case (run_idx_reg)
                3'd0:
                begin
                    beat_op   = OP_ERASE_PAGE;
                    beat_addr = run_dst_reg;
                end
                3'd1:
                begin
                    beat_op   = OP_COPY_PAGE;
                    beat_addr = run_dst_reg;
                    beat_src  = run_src_reg;
                end
                3'd2:
                begin
                    beat_op   = OP_MARK_USED;
                    beat_addr = addr_t'(run_mark_reg);
                end
                3'd3:
                begin
                    beat_op   = run_save_reg ? OP_SAVE_STATE : OP_ERASE_BLK;
                    beat_addr = run_save_reg ? '0 : run_addr_reg;
                end
                default:
                begin
                    beat_op   = OP_ERASE_BLK;
                    beat_addr = run_addr_reg;
                end
            endcase
        end
    end

    assign run_last = !run_erase_reg || (beat_op == OP_ERASE_BLK);
    assign m_tvalid = run_valid_reg;
    assign m_tuser  = beat_op;
    assign m_tlast  = run_last;
    assign m_tdata  = {run_moves_reg, run_pos_reg, beat_src, beat_addr};

    // ---------------- remainder unit ----------------
    logic [POS_W:0] rem_shift;
    logic           rem_ge;
    pos_t           rem_next;
    logic           mod_start_cfg;
    logic           restore_go;

    assign rem_shift = {mod_rem_reg, mod_w_reg[POS_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, pages});
    assign rem_next  = rem_ge ? POS_W'(rem_shift - {1'b0, pages}) : rem_shift[POS_W-1:0];

    assign mod_start_cfg = cfg_valid && cfg_ready && (cfg_index == REG_USABLE_PAGES);
    assign restore_go    = s1_adv && (s1_cmd_reg == CMD_RESTORE);

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg    <= '0;
            usable_pages_reg <= POS_W'(4047);
            page_shift_reg   <= SHIFT_W'(12);
            sector_shift_reg <= SHIFT_W'(16);
            mark_stride_reg  <= STRIDE_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_ADDR:    base_addr_reg    <= cfg_data[ADDR_W-1:0];
                REG_USABLE_PAGES: usable_pages_reg <= cfg_data[POS_W-1:0];
                REG_PAGE_SHIFT:   page_shift_reg   <= cfg_data[SHIFT_W-1:0];
                REG_SECTOR_SHIFT: sector_shift_reg <= cfg_data[SHIFT_W-1:0];
                REG_MARK_STRIDE:  mark_stride_reg  <= cfg_data[STRIDE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dummy_pos_reg  <= '0;
            wrap_count_reg <= '0;
            wrap_mod_reg   <= '0;
            mod_busy_reg   <= 1'b0;
            mod_cnt_reg    <= '0;
        end
        else
        begin
            if (s1_adv && is_erase && in_range)
            begin
                dummy_pos_reg  <= pos_next;
                wrap_count_reg <= moves_next;
                wrap_mod_reg   <= rot_next;
            end
            if (restore_go)
            begin
                dummy_pos_reg  <= restore_p;
                wrap_count_reg <= s1_rmoves_reg;
            end
            // restart the remainder on a restore or a write of usable_pages
            if (restore_go || mod_start_cfg)
            begin
                mod_busy_reg <= 1'b1;
                mod_cnt_reg  <= CNT_W'(POS_W);
            end
            else if (mod_busy_reg)
            begin
                mod_cnt_reg <= mod_cnt_reg - CNT_W'(1);
                if (mod_cnt_reg == CNT_W'(1))
                begin
                    mod_busy_reg <= 1'b0;
                    wrap_mod_reg <= rem_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (restore_go || mod_start_cfg)
        begin
            mod_rem_reg <= '0;
            mod_w_reg   <= restore_go ? s1_rmoves_reg : wrap_count_reg;
        end
        else if (mod_busy_reg)
        begin
            mod_rem_reg <= rem_next;
            mod_w_reg   <= {mod_w_reg[POS_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_cmd_reg    <= s_tuser;
            s1_vaddr_reg  <= s_tdata[31:0];
            s1_sector_reg <= s_tdata[47:32];
            s1_rpos_reg   <= s_tdata[63:48];
            s1_rmoves_reg <= s_tdata[79:64];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            run_idx_reg   <= '0;
        end
        else if (s1_adv && s1_has_result)
        begin
            run_valid_reg <= 1'b1;
            run_idx_reg   <= '0;
        end
        else if (run_valid_reg && m_tready)
        begin
            if (run_last)
                run_valid_reg <= 1'b0;
            else
                run_idx_reg <= run_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_has_result)
        begin
            run_erase_reg <= is_erase && in_range;
            run_op_reg    <= !in_range ? OP_RANGE_ERR : OP_ACCESS;
            run_addr_reg  <= in_range ? tr_addr : tr_voff;
            run_dst_reg   <= dst;
            run_src_reg   <= src;
            run_mark_reg  <= mark;
            run_save_reg  <= wraps;
            run_pos_reg   <= (is_erase && in_range) ? pos_next : dummy_pos_reg;
            run_moves_reg <= (is_erase && in_range) ? moves_next : wrap_count_reg;
        end
    end

`ifndef ASSERT_OFF
    a_rot_below_pages: assert property (@(posedge clk) disable iff (!rst_n)
        !mod_busy_reg |-> (wrap_mod_reg < pages))
        else $error("rotation count not below usable page count");

    a_fifth_beat_after_save: assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid_reg && run_idx_reg == 3'd4) |-> (run_erase_reg && run_save_reg))
        else $error("fifth erase beat without a state save");

    a_save_moves_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == OP_SAVE_STATE) |-> (run_moves_reg < pages))
        else $error("wrap count after save not reduced");

    a_restore_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
        restore_go |=> mod_busy_reg)
        else $error("restore did not start remainder unit");
`endif

endmodule

[dv/flash_wear_level_translator_core_tb.sv]
// ----------------------------------------------------------------------------
// flash_wear_level_translator_core_tb: self-checking bench for the translator
// drives translate, erase, restore and unknown commands through several
// register settings, predicts every flash operation and checks each result
// ----------------------------------------------------------------------------
module flash_wear_level_translator_core_tb;

    import fwlt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    // covers the input and result registers and the remainder pass
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 17;
    localparam int MAX_REPORTS    = 10;

    localparam cmd_t CMD_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        cmd_t cmd;
        addr_t vaddr;
        pos_t sector;
        pos_t rpos;
        pos_t rmoves;
    } command_t;

    typedef struct packed {
        op_t op;
        addr_t addr;
        addr_t src;
        pos_t pos;
        pos_t moves;
        logic last;
    } flash_op_t;

    typedef struct packed {
        command_t cmd;
        bit typed;
        op_t op;
        addr_t addr;
    } directed_row_t;

    localparam int N_DIRECTED = 20;
    localparam directed_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        '{'{CMD_TRANSLATE, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, OP_ACCESS,
          32'h0000_1000},
        '{'{CMD_TRANSLATE, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, OP_RANGE_ERR,
          32'hFFFF_FFFF},
        '{'{CMD_TRANSLATE, 32'h00FC_EFFF, 16'h0000, 16'h0000, 16'h0000}, 1'b0, OP_ACCESS,
          32'h0},
        '{'{CMD_TRANSLATE, 32'h00FC_F000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, OP_RANGE_ERR,
          32'h00FC_F000},
        '{'{CMD_ERASE, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, OP_ACCESS, 32'h0},
        '{'{CMD_ERASE, 32'h0000_0000, 16'hFFFF, 16'h0000, 16'h0000}, 1'b1, OP_RANGE_ERR,
          32'hFFFF_0000},
        '{'{CMD_ERASE, 32'h0000_0000, 16'h00FD, 16'h0000, 16'h0000}, 1'b1, OP_RANGE_ERR,
          32'h00FD_0000},
        '{'{CMD_ERASE, 32'h0000_0000, 16'h00FC, 16'h0000, 16'h0000}, 1'b0, OP_ACCESS, 32'h0},
        '{'{CMD_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, OP_ACCESS, 32'h0},
        // position saturates, wrap count kept above the page count
        '{'{CMD_RESTORE, 32'h0000_0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b0, OP_ACCESS, 32'h0},
        '{'{CMD_TRANSLATE, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, OP_ACCESS,
          32'h0},
        '{'{CMD_ERASE, 32'h0000_0000, 16'h0001, 16'h0000, 16'h0000}, 1'b0, OP_ACCESS, 32'h0},
        // wrap count reaches the page count on the next wrap and clears
        '{'{CMD_RESTORE, 32'h0000_0000, 16'h0000, 16'd4047, 16'd4046}, 1'b0, OP_ACCESS,
          32'h0},
        '{'{CMD_ERASE, 32'h0000_0000, 16'h0002, 16'h0000, 16'h0000}, 1'b0, OP_ACCESS, 32'h0},
        '{'{CMD_RESTORE, 32'h0000_0000, 16'h0000, 16'd5, 16'd3}, 1'b0, OP_ACCESS, 32'h0},
        '{'{CMD_TRANSLATE, 32'h0000_4FFF, 16'h0000, 16'h0000, 16'h0000}, 1'b0, OP_ACCESS,
          32'h0},
        '{'{CMD_TRANSLATE, 32'h0000_5000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, OP_ACCESS,
          32'h0},
        '{'{CMD_TRANSLATE, 32'h0000_1FFF, 16'h0000, 16'h0000, 16'h0000}, 1'b0, OP_ACCESS,
          32'h0},
        '{'{CMD_RESTORE, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, OP_ACCESS, 32'h0},
        '{'{CMD_TRANSLATE, 32'h00FC_EFFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, OP_ACCESS,
          32'h00FC_FFFF}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // vaddr, sector, restore_pos, restore_moves
    logic [CMD_W-1:0]      s_tuser = '0;   // cmd
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // addr, copy_src, pos_out, moves_out
    logic [OP_W-1:0]       m_tuser;        // op
    logic                  m_tlast;

    // shadow registers and rotation state
    addr_t       cfg_base   = 32'd0;
    logic [15:0] cfg_pages  = 16'd4047;
    logic [4:0]  cfg_pshift = 5'd12;
    logic [4:0]  cfg_sshift = 5'd16;
    logic [8:0]  cfg_stride = 9'd16;
    pos_t        dummy_slot = '0;
    logic [15:0] wrap_total = '0;

    flash_op_t flash_ops_due[$];
    flash_op_t seen_op;
    flash_op_t want_op;

    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned mismatches    = 0;
    int unsigned ops_checked   = 0;
    int unsigned wraps_seen    = 0;
    int unsigned range_errors  = 0;
    int unsigned n_translate   = 0;
    int unsigned n_erase       = 0;
    int unsigned n_restore     = 0;
    int unsigned n_unknown     = 0;
    int unsigned settings_run  = 1;
    int unsigned quiet_cycles  = 0;

    flash_wear_level_translator_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #4 clk = ~clk;

    function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int unsigned pages_in_use();
        return (cfg_pages < 16'd2) ? 2 : int'(cfg_pages);
    endfunction

    function automatic int unsigned page_bits();
        return clamp_u(cfg_pshift, 8, 16);
    endfunction

    function automatic bit [63:0] region_bytes();
        return 64'(pages_in_use()) << page_bits();
    endfunction

    // rotate back by the wrap count, skip the dummy page, add the base
    function automatic addr_t map_addr(input bit [63:0] voff);
        bit [63:0] span;
        bit [63:0] rot;
        bit [63:0] r;
        span = region_bytes();
        rot  = 64'(int'(wrap_total) % pages_in_use()) << page_bits();
        r    = (voff + span - rot) % span;
        if (r >= (64'(dummy_slot) << page_bits()))
            r = r + (64'd1 << page_bits());
        return addr_t'(64'(cfg_base) + r);
    endfunction

    function automatic flash_op_t make_op(input op_t op, input bit [63:0] a,
                                          input bit [63:0] s);
        flash_op_t f;
        f = '0;
        f.op   = op;
        f.addr = addr_t'(a);
        f.src  = addr_t'(s);
        return f;
    endfunction

    task automatic expand_command(input command_t c);
        flash_op_t run[$];
        bit [63:0] va;
        bit [63:0] dst;
        bit [63:0] src;
        int unsigned slots;
        int unsigned nxt;
        int unsigned np;
        case (c.cmd)
            CMD_TRANSLATE:
            begin
                va = 64'(c.vaddr);
                if (va >= region_bytes())
                    run.push_back(make_op(OP_RANGE_ERR, va, 0));
                else
                    run.push_back(make_op(OP_ACCESS, 64'(map_addr(va)), 0));
            end
            CMD_ERASE:
            begin
                va = (64'(c.sector) << clamp_u(cfg_sshift, 8, 18)) & 64'hFFFF_FFFF;
                if (va >= region_bytes())
                    run.push_back(make_op(OP_RANGE_ERR, va, 0));
                else
                begin
                    slots = pages_in_use() + 1;
                    nxt = int'(dummy_slot) + 1;
                    if (nxt >= slots)
                        nxt = 0;
                    dst = 64'(cfg_base) + (64'(dummy_slot) << page_bits());
                    src = 64'(cfg_base) + (64'(nxt) << page_bits());
                    run.push_back(make_op(OP_ERASE_PAGE, dst, 0));
                    run.push_back(make_op(OP_COPY_PAGE, dst, src));
                    run.push_back(make_op(OP_MARK_USED,
                                          64'(dummy_slot) * clamp_u(cfg_stride, 1, 256), 0));
                    np = int'(dummy_slot) + 1;
                    if (np >= slots)
                    begin
                        np = 0;
                        wrap_total = wrap_total + 16'd1;
                        if (wrap_total >= slots - 1)
                            wrap_total = '0;
                        run.push_back(make_op(OP_SAVE_STATE, 0, 0));
                    end
                    dummy_slot = pos_t'(np);
                    run.push_back(make_op(OP_ERASE_BLK, 64'(map_addr(va)), 0));
                end
            end
            CMD_RESTORE:
            begin
                dummy_slot = (c.rpos > pages_in_use()) ? pos_t'(pages_in_use()) : c.rpos;
                wrap_total = c.rmoves;
            end
            default:
            begin
            end
        endcase
        foreach (run[k])
        begin
            run[k].pos   = dummy_slot;
            run[k].moves = wrap_total;
            run[k].last  = (k == run.size() - 1);
            flash_ops_due.push_back(run[k]);
        end
    endtask

    function automatic command_t random_command();
        command_t c;
        bit [63:0] span;
        bit [63:0] top_sector;
        int unsigned pick;
        span = region_bytes();
        c.vaddr  = $urandom;
        c.sector = pos_t'($urandom);
        c.rpos   = pos_t'($urandom);
        c.rmoves = pos_t'($urandom);
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            c.cmd = CMD_TRANSLATE;
            case ($urandom_range(6))
                0: c.vaddr = addr_t'(span - 64'($urandom_range(1)));
                1: c.vaddr = $urandom;
                default: c.vaddr = addr_t'(64'($urandom) % span);
            endcase
        end
        else if (pick < 75)
        begin
            c.cmd = CMD_ERASE;
            top_sector = (span - 1) >> clamp_u(cfg_sshift, 8, 18);
            if (top_sector > 64'd65535)
                top_sector = 64'd65535;
            if ($urandom_range(4) != 0)
                c.sector = pos_t'($urandom_range(int'(top_sector), 0));
        end
        else if (pick < 90)
        begin
            c.cmd = CMD_RESTORE;
            if ($urandom_range(1) == 0)
                c.rpos = pos_t'($urandom_range(pages_in_use() + 1, 0));
            case ($urandom_range(2))
                0: c.rmoves = pos_t'(pages_in_use() - 1 + $urandom_range(1));
                1: c.rmoves = pos_t'($urandom_range(pages_in_use(), 0));
                default: ;
            endcase
        end
        else
            c.cmd = CMD_UNKNOWN;
        return c;
    endfunction

    task automatic send_command(input command_t c);
        bit took;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= {c.rmoves, c.rpos, c.sector, c.vaddr};
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        case (c.cmd)
            CMD_TRANSLATE: n_translate++;
            CMD_ERASE:     n_erase++;
            CMD_RESTORE:   n_restore++;
            default:       n_unknown++;
        endcase
        expand_command(c);
    endtask

    task automatic run_random(input int unsigned count);
        command_t c;
        int unsigned sent;
        sent = 0;
        while (sent < count)
        begin
            c = random_command();
            send_command(c);
            if (c.cmd != CMD_UNKNOWN)
                sent++;
        end
    endtask

    // batches keep cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        case (idx)
            REG_BASE_ADDR:    cfg_base   = val;
            REG_USABLE_PAGES: cfg_pages  = val[15:0];
            REG_PAGE_SHIFT:   cfg_pshift = val[4:0];
            REG_SECTOR_SHIFT: cfg_sshift = val[4:0];
            REG_MARK_STRIDE:  cfg_stride = val[8:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (flash_ops_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input addr_t base, input logic [31:0] pages,
                                 input logic [31:0] pshift, input logic [31:0] sshift,
                                 input logic [31:0] stride);
        settle();
        write_reg(REG_BASE_ADDR, base);
        write_reg(REG_USABLE_PAGES, pages);
        write_reg(REG_PAGE_SHIFT, pshift);
        write_reg(REG_SECTOR_SHIFT, sshift);
        write_reg(REG_MARK_STRIDE, stride);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    task automatic note_mismatch(input string what, input flash_op_t want,
                                 input flash_op_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("mismatch: %s", what);
            $display("  expected op=%0d addr=%h src=%h pos=%0d moves=%0d last=%0d",
                     want.op, want.addr, want.src, want.pos, want.moves, want.last);
            $display("  actual   op=%0d addr=%h src=%h pos=%0d moves=%0d last=%0d",
                     got.op, got.addr, got.src, got.pos, got.moves, got.last);
        end
    endtask

    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= sink_idle_pct);

    // transactions are sampled mid-cycle, where all inputs and outputs are settled
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_op.op    = m_tuser;
            seen_op.addr  = m_tdata[31:0];
            seen_op.src   = m_tdata[63:32];
            seen_op.pos   = m_tdata[79:64];
            seen_op.moves = m_tdata[95:80];
            seen_op.last  = m_tlast;
            ops_checked++;
            if (flash_ops_due.size() == 0)
                note_mismatch("result with nothing expected", '0, seen_op);
            else
            begin
                want_op = flash_ops_due.pop_front();
                if (want_op.op == OP_SAVE_STATE)
                    wraps_seen++;
                if (want_op.op == OP_RANGE_ERR)
                    range_errors++;
                if (seen_op !== want_op)
                    note_mismatch("result differs", want_op, seen_op);
            end
        end
    end

    always @(negedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, flash_ops_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        flash_op_t typed_op;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 15;
        sink_idle_pct = 45;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_command(DIRECTED_ROWS[i].cmd);
            // this row's single result is the newest one queued
            if (DIRECTED_ROWS[i].typed && flash_ops_due.size() != 0)
            begin
                typed_op = flash_ops_due[flash_ops_due.size() - 1];
                typed_op.op   = DIRECTED_ROWS[i].op;
                typed_op.addr = DIRECTED_ROWS[i].addr;
                flash_ops_due[flash_ops_due.size() - 1] = typed_op;
            end
        end
        run_random(RANDOM_ITEMS);

        // smallest region, wrapping base: the dummy page cycles every few erases
        apply_setting(32'hFFFF_F000, 2, 8, 8, 1);
        run_random(RANDOM_ITEMS);

        src_idle_pct  = 45;
        sink_idle_pct = 15;
        apply_setting(32'h8000_0000, 65535, 16, 18, 256);
        run_random(RANDOM_ITEMS);

        // out-of-range values are clamped by the block
        apply_setting($urandom, 1, 31, 0, 0);
        @(posedge clk);
        write_reg(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
        run_random(RANDOM_ITEMS);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        apply_setting($urandom, 0, 0, 31, 511);
        run_random(RANDOM_ITEMS);

        apply_setting($urandom, $urandom_range(40, 2), $urandom_range(16, 8),
                      $urandom_range(18, 8), $urandom_range(256, 1));
        run_random(RANDOM_ITEMS);

        settle();
        if (flash_ops_due.size() != 0)
        begin
            $display("%0d expected results never arrived", flash_ops_due.size());
            mismatches += flash_ops_due.size();
        end
        $display("sent %0d translates, %0d erases, %0d restores, %0d unknown over %0d settings",
                 n_translate, n_erase, n_restore, n_unknown, settings_run);
        $display("checked %0d results: %0d dummy wraps, %0d range errors, %0d mismatches",
                 ops_checked, wraps_seen, range_errors, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
